[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the frame filter.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, held off during reset.
`define ASSERT_AT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/rfd_pkg.sv]
// Types and constants for the receive frame filter with duplicate suppression.
// No dependencies.
package rfd_pkg;

	localparam int SOURCE_COUNT = 8;
	localparam int MAX_PAYLOAD  = 102;
	localparam int SRC_W        = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

	localparam int HDR_BYTES = 9;
	localparam int FCS_BYTES = 2;
	localparam int MIN_LEN   = HDR_BYTES + FCS_BYTES;
	localparam int MAX_LEN   = MIN_LEN + MAX_PAYLOAD;

	// byte positions within the frame, the length byte being position 0
	localparam logic [6:0] POS_FC_LO  = 7'd1;
	localparam logic [6:0] POS_FC_HI  = 7'd2;
	localparam logic [6:0] POS_SEQ    = 7'd3;
	localparam logic [6:0] POS_SRC_LO = 7'd8;
	localparam logic [6:0] POS_SRC_HI = 7'd9;

	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_BAD_FC  = 3'd1;
	localparam logic [2:0] ST_BAD_LEN = 3'd2;
	localparam logic [2:0] ST_BAD_SRC = 3'd3;
	localparam logic [2:0] ST_DUP     = 3'd4;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'b001,
		MODE_HEADER  = 3'b010,
		MODE_PAYLOAD = 3'b100
	} mode_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] out_status;
		logic       out_last;
	} out_word_t;

endpackage

[rtl/radio_rx_frame_filter_dedup_top.sv]
// Top level of the 802.15.4 receive frame filter with per-source duplicate drop.
// Depends on rfd_pkg and assert_macros.svh.

// Takes one received byte per word, the length byte first (frame_start set),
// checks frame control, length (11 to 11 + MAX_PAYLOAD) and source (below
// SOURCE_COUNT), and drops a sequence number repeated from the same source.
// An accepted frame gives the source index and then its payload bytes, the last
// one marked; a rejected frame gives one status word with out_last set. Each
// byte passes through the input register and then the result register, and
// one byte is taken every cycle; the result register only holds off input
// when it is full and stalled and the byte in the input register would
// produce a word.
module radio_rx_frame_filter_dedup_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	input  rfd_pkg::in_word_t  frame_word,
	output logic              result_valid,
	input  logic              result_stall,
	output rfd_pkg::out_word_t result_word
);

	`include "assert_macros.svh"

	logic               valid_s1;
	rfd_pkg::in_word_t  word_s1;

	rfd_pkg::mode_t mode_q, mode_d;
	logic [6:0] pos_q, pos_d;
	logic [7:0] len_q, len_d;
	logic [7:0] fc_lo_q, fc_lo_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] src_lo_q, src_lo_d;

	logic [rfd_pkg::SOURCE_COUNT-1:0] seen_valid_q;
	logic [7:0]                       seen_seq_q [rfd_pkg::SOURCE_COUNT];

	logic                    res_want;
	rfd_pkg::out_word_t      res_d;
	rfd_pkg::out_word_t      res_q;
	logic                    res_valid_q;
	logic                    seen_we;
	logic [15:0]             src_full;
	logic [rfd_pkg::SRC_W-1:0] src_idx;
	logic                    go_s1;
	logic                    step_s1;
	logic                    res_load;

	function automatic logic fc_ok(input logic [7:0] lo, input logic [7:0] hi);
		fc_ok = (lo[2:0] == 3'b001) && !lo[3] && lo[6] &&
		        (hi[3:2] == 2'b10) && (hi[7:6] == 2'b10);
	endfunction

	assign src_full = {word_s1.rx_byte, src_lo_q};
	assign src_idx  = src_full[rfd_pkg::SRC_W-1:0];

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		len_d    = len_q;
		fc_lo_d  = fc_lo_q;
		seq_d    = seq_q;
		src_lo_d = src_lo_q;
		res_want = 1'b0;
		res_d    = '0;
		seen_we  = 1'b0;
		if (word_s1.frame_start) begin
			len_d  = word_s1.rx_byte;
			pos_d  = 7'd1;
			mode_d = rfd_pkg::MODE_HEADER;
		end else if (mode_q != rfd_pkg::MODE_IDLE) begin
			pos_d = pos_q + 7'd1;
			if (mode_q == rfd_pkg::MODE_HEADER) begin
				case (pos_q)
					rfd_pkg::POS_FC_LO: fc_lo_d = word_s1.rx_byte;
					rfd_pkg::POS_FC_HI: begin
						if (!fc_ok(fc_lo_q, word_s1.rx_byte)) begin
							res_want   = 1'b1;
							res_d.out_status = rfd_pkg::ST_BAD_FC;
							res_d.out_last   = 1'b1;
							mode_d     = rfd_pkg::MODE_IDLE;
						end else if (len_q < 8'(rfd_pkg::MIN_LEN) ||
						             len_q > 8'(rfd_pkg::MAX_LEN)) begin
							res_want   = 1'b1;
							res_d.out_status = rfd_pkg::ST_BAD_LEN;
							res_d.out_last   = 1'b1;
							mode_d     = rfd_pkg::MODE_IDLE;
						end
					end
					rfd_pkg::POS_SEQ:    seq_d = word_s1.rx_byte;
					rfd_pkg::POS_SRC_LO: src_lo_d = word_s1.rx_byte;
					rfd_pkg::POS_SRC_HI: begin
						res_want       = 1'b1;
						res_d.out_last = 1'b1;
						mode_d         = rfd_pkg::MODE_IDLE;
						if (src_full >= 16'(rfd_pkg::SOURCE_COUNT)) begin
							res_d.out_status = rfd_pkg::ST_BAD_SRC;
						end else if (seen_valid_q[src_idx] && seen_seq_q[src_idx] == seq_q) begin
							res_d.out_status = rfd_pkg::ST_DUP;
						end else begin
							seen_we          = 1'b1;
							res_d.out_byte   = 8'(src_idx);
							res_d.out_status = rfd_pkg::ST_DATA;
							// empty payload: the source index closes the frame
							if (len_q != 8'(rfd_pkg::MIN_LEN)) begin
								res_d.out_last = 1'b0;
								mode_d         = rfd_pkg::MODE_PAYLOAD;
							end
						end
					end
					default: ;
				endcase
			end else begin
				res_want         = 1'b1;
				res_d.out_byte   = word_s1.rx_byte;
				res_d.out_status = rfd_pkg::ST_DATA;
				// last payload byte sits two before the end (checksum follows)
				if ((8'(pos_q) + 8'(rfd_pkg::FCS_BYTES)) >= len_q) begin
					res_d.out_last = 1'b1;
					mode_d         = rfd_pkg::MODE_IDLE;
				end
			end
		end
	end

	assign go_s1       = !res_want || !res_valid_q || !result_stall;
	assign step_s1     = valid_s1 && go_s1;
	assign res_load    = step_s1 && res_want;
	assign frame_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_valid && !frame_stall) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			word_s1 <= frame_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= rfd_pkg::MODE_IDLE;
			pos_q        <= '0;
			len_q        <= '0;
			fc_lo_q      <= '0;
			seq_q        <= '0;
			src_lo_q     <= '0;
			seen_valid_q <= '0;
		end else if (step_s1) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			len_q    <= len_d;
			fc_lo_q  <= fc_lo_d;
			seq_q    <= seq_d;
			src_lo_q <= src_lo_d;
			if (seen_we) begin
				seen_valid_q[src_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1 && seen_we) begin
			seen_seq_q[src_idx] <= seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result_word  = res_q;

	`ASSERT_AT_CLK(a_reject_shape, res_valid_q && res_q.out_status != rfd_pkg::ST_DATA |-> res_q.out_byte == 8'd0 && res_q.out_last, "reject word must carry byte 0 and last")
	`ASSERT_AT_CLK(a_last_goes_idle, res_load && res_d.out_last |=> mode_q == rfd_pkg::MODE_IDLE, "frame end must leave the filter idle")
	`ASSERT_NEVER(a_stall_empty, frame_stall && !valid_s1, "input stalled with empty input register")
	`ASSERT_AT_CLK(a_held_word, res_valid_q && result_stall |=> res_valid_q && $stable(res_q), "stalled result word changed")

endmodule
